/* sv/imoe_pkg.sv */
// imoe_pkg: operation codes, type codes, stream field layout and type helpers
// for the ir micro-op executor; no dependencies
package imoe_pkg;

    localparam int SLOTS  = 64;
    localparam int SLOT_W = $clog2(SLOTS);

    // operation codes
    localparam logic [4:0] F_CONST    = 5'd0;
    localparam logic [4:0] F_WREG     = 5'd1;
    localparam logic [4:0] F_STORE    = 5'd2;
    localparam logic [4:0] F_ADD      = 5'd3;
    localparam logic [4:0] F_SUB      = 5'd4;
    localparam logic [4:0] F_MUL      = 5'd5;
    localparam logic [4:0] F_AND      = 5'd6;
    localparam logic [4:0] F_OR       = 5'd7;
    localparam logic [4:0] F_XOR      = 5'd8;
    localparam logic [4:0] F_SHL      = 5'd9;
    localparam logic [4:0] F_SHR      = 5'd10;
    localparam logic [4:0] F_SAR      = 5'd11;
    localparam logic [4:0] F_NOT      = 5'd12;
    localparam logic [4:0] F_EQ       = 5'd13;
    localparam logic [4:0] F_NE       = 5'd14;
    localparam logic [4:0] F_ULT      = 5'd15;
    localparam logic [4:0] F_SLT      = 5'd16;
    localparam logic [4:0] F_SELECT   = 5'd17;
    localparam logic [4:0] F_SETPC    = 5'd18;
    localparam logic [4:0] F_BRANCH   = 5'd19;
    localparam logic [4:0] F_BRANCHIF = 5'd20;
    localparam logic [4:0] F_EXIT     = 5'd21;
    localparam logic [4:0] F_RETIRE   = 5'd22;

    // result type codes
    localparam logic [2:0] T_BOOL = 3'd1;
    localparam logic [2:0] T_I8   = 3'd2;
    localparam logic [2:0] T_I16  = 3'd3;
    localparam logic [2:0] T_I32  = 3'd4;
    localparam logic [2:0] T_I64  = 3'd5;

    // request actions
    localparam logic [1:0] A_NONE  = 2'd0;
    localparam logic [1:0] A_WREG  = 2'd1;
    localparam logic [1:0] A_STORE = 2'd2;
    localparam logic [1:0] A_PC    = 2'd3;

    localparam int IN_W  = 232;
    localparam int OUT_W = 88;

    function automatic logic [63:0] type_mask(input logic [2:0] code);
        case (code)
            T_BOOL:  type_mask = 64'h1;
            T_I8:    type_mask = 64'hFF;
            T_I16:   type_mask = 64'hFFFF;
            T_I32:   type_mask = 64'hFFFF_FFFF;
            T_I64:   type_mask = '1;
            default: type_mask = '0;
        endcase
    endfunction

    function automatic logic [6:0] type_width(input logic [2:0] code);
        case (code)
            T_BOOL:  type_width = 7'd1;
            T_I8:    type_width = 7'd8;
            T_I16:   type_width = 7'd16;
            T_I32:   type_width = 7'd32;
            T_I64:   type_width = 7'd64;
            default: type_width = 7'd0;
        endcase
    endfunction

    // top bit of the type: the sign bit
    function automatic logic [63:0] type_sign(input logic [2:0] code);
        case (code)
            T_BOOL:  type_sign = 64'h1;
            T_I8:    type_sign = 64'h80;
            T_I16:   type_sign = 64'h8000;
            T_I32:   type_sign = 64'h8000_0000;
            T_I64:   type_sign = 64'h8000_0000_0000_0000;
            default: type_sign = '0;
        endcase
    endfunction

endpackage

/* sv/imoe_ram.sv */
// imoe_ram: value file copy, one write port and one registered read port
// depends on imoe_pkg for depth and index width
module imoe_ram (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [imoe_pkg::SLOT_W-1:0] i_wr_addr,
    input  logic [63:0]               i_wr_data,
    input  logic                      i_rd_en,
    input  logic [imoe_pkg::SLOT_W-1:0] i_rd_addr,
    output logic [63:0]               o_rd_data
);

    logic [63:0] r_mem [imoe_pkg::SLOTS];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

/* sv/ir_micro_op_executor_unit.sv */
// ir_micro_op_executor_unit: top level of the ir micro-op executor
// depends on imoe_pkg and imoe_ram
// an accepted item passes the execute stage registers, then the output register
// throughput: one item per cycle unless the output stalls; mul holds the
//   execute stage to register partial products (64-bit product from 32-bit parts)
// value file: four replicated memories read at the input transfer, with
//   forwarding of the previous write; per-slot valid bits clear on each last item
// reset: synchronous active low, clears valid bits, flags and stage valids
module ir_micro_op_executor_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // func, result_type, has_result, result_slot, a_tag, a_payload, b_tag,
    // b_payload, c_tag, c_payload, cond_slot, zero fill
    input  logic [imoe_pkg::IN_W-1:0] i_s_tdata,
    input  logic                      i_s_tlast,  // last_op
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // action, target, data, branch_taken, exit_requested, cycle_condition,
    // retired, zero fill
    output logic [imoe_pkg::OUT_W-1:0] o_m_tdata,
    output logic                      o_m_tlast   // instr_done
);

    localparam int SW = imoe_pkg::SLOT_W;

    // execute stage registers
    logic        r_s1_vld;
    logic [4:0]  r_func;
    logic [2:0]  r_rtype;
    logic        r_has;
    logic [5:0]  r_rslot;
    logic [3:0]  r_at, r_bt, r_ct;
    logic [63:0] r_ap, r_bp, r_cp;
    logic        r_last;
    logic [6:0]  r_cslot;

    // instruction state
    logic [imoe_pkg::SLOTS-1:0] r_valid;
    logic r_branch, r_exit, r_ret;
    logic n_branch, n_exit, n_ret;

    // last write, for forwarding
    logic          r_fw_en;
    logic [SW-1:0] r_fw_addr;
    logic [63:0]   r_fw_data;

    // multiply partial products
    logic        r_mul_ph;
    logic [63:0] r_p0;
    logic [31:0] r_p1, r_p2;

    // output register
    logic        r_o_vld;
    logic [imoe_pkg::OUT_W-1:0] r_o_data;
    logic        r_o_last;

    logic        accept, s1_adv, mul_busy, skip;
    logic [63:0] rd_a, rd_b, rd_c, rd_d;
    logic [63:0] va, vb, vc, vd;
    logic [63:0] fa, fb, fc;
    logic [63:0] value, m, sext, src, om, sg;
    logic [6:0]  w, ow;
    logic [5:0]  sh;
    logic [1:0]  action;
    logic [15:0] target;
    logic [63:0] data;
    logic        wr_en, cc;
    logic [63:0] wr_data;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = !r_s1_vld || s1_adv;

    // value file copies: a, b, c operand ports and condition port
    imoe_ram u_ram_a (.i_clk, .i_wr_en(wr_en), .i_wr_addr(r_rslot[SW-1:0]),
        .i_wr_data(wr_data), .i_rd_en(accept), .i_rd_addr(i_s_tdata[19+SW-1:19]),
        .o_rd_data(rd_a));
    imoe_ram u_ram_b (.i_clk, .i_wr_en(wr_en), .i_wr_addr(r_rslot[SW-1:0]),
        .i_wr_data(wr_data), .i_rd_en(accept), .i_rd_addr(i_s_tdata[87+SW-1:87]),
        .o_rd_data(rd_b));
    imoe_ram u_ram_c (.i_clk, .i_wr_en(wr_en), .i_wr_addr(r_rslot[SW-1:0]),
        .i_wr_data(wr_data), .i_rd_en(accept), .i_rd_addr(i_s_tdata[155+SW-1:155]),
        .o_rd_data(rd_c));
    imoe_ram u_ram_d (.i_clk, .i_wr_en(wr_en), .i_wr_addr(r_rslot[SW-1:0]),
        .i_wr_data(wr_data), .i_rd_en(accept), .i_rd_addr(i_s_tdata[219+SW-1:219]),
        .o_rd_data(rd_d));

    // slot reads: valid bit, forwarding of the previous write, range check
    always_comb begin
        va = (r_ap[63:SW] == '0 && r_valid[r_ap[SW-1:0]])
           ? ((r_fw_en && r_fw_addr == r_ap[SW-1:0]) ? r_fw_data : rd_a) : '0;
        vb = (r_bp[63:SW] == '0 && r_valid[r_bp[SW-1:0]])
           ? ((r_fw_en && r_fw_addr == r_bp[SW-1:0]) ? r_fw_data : rd_b) : '0;
        vc = (r_cp[63:SW] == '0 && r_valid[r_cp[SW-1:0]])
           ? ((r_fw_en && r_fw_addr == r_cp[SW-1:0]) ? r_fw_data : rd_c) : '0;
        vd = (r_cslot[6:SW] == '0 && r_valid[r_cslot[SW-1:0]])
           ? ((r_fw_en && r_fw_addr == r_cslot[SW-1:0]) ? r_fw_data : rd_d) : '0;
        fa = r_at[3] ? va : (r_ap & imoe_pkg::type_mask(r_at[2:0]));
        fb = r_bt[3] ? vb : (r_bp & imoe_pkg::type_mask(r_bt[2:0]));
        fc = r_ct[3] ? vc : (r_cp & imoe_pkg::type_mask(r_ct[2:0]));
    end

    assign skip     = r_ret || (r_exit && r_func != imoe_pkg::F_RETIRE);
    assign mul_busy = r_func == imoe_pkg::F_MUL && !skip && !r_mul_ph;
    assign s1_adv   = r_s1_vld && !mul_busy && (!r_o_vld || i_m_tready);

    // execute
    always_comb begin
        m      = imoe_pkg::type_mask(r_rtype);
        w      = imoe_pkg::type_width(r_rtype);
        sh     = fb[5:0];
        src    = fa & m;
        sext   = ((src & imoe_pkg::type_sign(r_rtype)) != '0) ? (src | ~m) : src;
        om     = imoe_pkg::type_mask(r_at[2:0]);
        ow     = imoe_pkg::type_width(r_at[2:0]);
        sg     = imoe_pkg::type_sign(r_at[2:0]);
        value  = '0;
        action = imoe_pkg::A_NONE;
        target = '0;
        data   = '0;
        n_branch = r_branch;
        n_exit   = r_exit;
        n_ret    = r_ret;
        if (!skip) begin
            case (r_func)
                imoe_pkg::F_CONST: value = fa;
                imoe_pkg::F_WREG: begin
                    action = imoe_pkg::A_WREG;
                    target = r_ap[15:0];
                    data   = fb;
                end
                imoe_pkg::F_STORE: begin
                    action = imoe_pkg::A_STORE;
                    target = fa[15:0];
                    data   = {56'd0, fb[7:0]};
                end
                imoe_pkg::F_ADD: value = fa + fb;
                imoe_pkg::F_SUB: value = fa - fb;
                imoe_pkg::F_MUL: value = r_p0 + {r_p1 + r_p2, 32'd0};
                imoe_pkg::F_AND: value = fa & fb;
                imoe_pkg::F_OR:  value = fa | fb;
                imoe_pkg::F_XOR: value = fa ^ fb;
                imoe_pkg::F_SHL:
                    value = (w == '0 || {1'b0, sh} >= w) ? '0 : ((fa << sh) & m);
                imoe_pkg::F_SHR:
                    value = (w == '0 || {1'b0, sh} >= w) ? '0 : (src >> sh);
                imoe_pkg::F_SAR:
                    value = (w == '0) ? '0 : (64'($signed(sext) >>> sh) & m);
                imoe_pkg::F_NOT: value = ~fa;
                imoe_pkg::F_EQ:  value = {63'd0, fa == fb};
                imoe_pkg::F_NE:  value = {63'd0, fa != fb};
                imoe_pkg::F_ULT: value = {63'd0, fa < fb};
                imoe_pkg::F_SLT:
                    value = {63'd0, ow != '0 && (((fa & om) ^ sg) < ((fb & om) ^ sg))};
                imoe_pkg::F_SELECT: value = (fa != '0) ? fb : fc;
                imoe_pkg::F_SETPC: begin
                    action = imoe_pkg::A_PC;
                    data   = fa;
                end
                imoe_pkg::F_BRANCH: begin
                    action   = imoe_pkg::A_PC;
                    data     = r_ap;
                    n_branch = 1'b1;
                end
                imoe_pkg::F_BRANCHIF: begin
                    if (fa != '0) begin
                        action   = imoe_pkg::A_PC;
                        data     = r_bp;
                        n_branch = 1'b1;
                    end
                end
                imoe_pkg::F_EXIT:   n_exit = 1'b1;
                imoe_pkg::F_RETIRE: n_ret  = 1'b1;
                default: value = '0;
            endcase
        end
        wr_data = value & m;
        wr_en   = s1_adv && !skip && r_has;
        // condition seen after this item's own write
        cc = (r_cslot[6:SW] == '0)
           && ((!skip && r_has && r_rslot[SW-1:0] == r_cslot[SW-1:0])
               ? (wr_data != '0) : (vd != '0));
    end

    // execute stage capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_s_tdata[4:0];
            r_rtype <= i_s_tdata[7:5];
            r_has   <= i_s_tdata[8];
            r_rslot <= i_s_tdata[14:9];
            r_at    <= i_s_tdata[18:15];
            r_ap    <= i_s_tdata[82:19];
            r_bt    <= i_s_tdata[86:83];
            r_bp    <= i_s_tdata[150:87];
            r_ct    <= i_s_tdata[154:151];
            r_cp    <= i_s_tdata[218:155];
            r_cslot <= i_s_tdata[225:219];
            r_last  <= i_s_tlast;
        end
    end

    // multiply: partial products first, sum on the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_ph <= 1'b0;
        end else if (s1_adv) begin
            r_mul_ph <= 1'b0;
        end else if (r_s1_vld && mul_busy) begin
            r_mul_ph <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_busy) begin
            r_p0 <= fa[31:0] * fb[31:0];
            r_p1 <= 32'(fa[31:0] * fb[63:32]);
            r_p2 <= 32'(fa[63:32] * fb[31:0]);
        end
    end

    // valid bits and flags, cleared after the last item of an instruction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_branch <= 1'b0;
            r_exit   <= 1'b0;
            r_ret    <= 1'b0;
            r_fw_en  <= 1'b0;
        end else if (s1_adv) begin
            r_fw_en <= wr_en;
            if (r_last) begin
                r_valid  <= '0;
                r_branch <= 1'b0;
                r_exit   <= 1'b0;
                r_ret    <= 1'b0;
            end else begin
                if (wr_en) begin
                    r_valid[r_rslot[SW-1:0]] <= 1'b1;
                end
                r_branch <= n_branch;
                r_exit   <= n_exit;
                r_ret    <= n_ret;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_fw_addr <= r_rslot[SW-1:0];
            r_fw_data <= wr_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s1_adv) begin
            r_o_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_last <= r_last;
            r_o_data <= {2'd0,
                         r_last & n_ret, r_last & cc, r_last & n_exit, r_last & n_branch,
                         data, target, action};
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;

endmodule
